// File: src/sstf_pkg.sv
package sstf_pkg;

	localparam int MAX_PENDING = 32;
	localparam int CNT_W = $clog2(MAX_PENDING + 1);
	localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int CYL_W = 16;
	localparam int SUM_W = 22;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef logic [CYL_W-1:0] cyl_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		K_NOP,
		K_LOAD,
		K_RUN,
		K_LOAD_RUN
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		cyl_t       cylinder;
		cyl_t       start_head;
	} item_t;

	typedef struct packed {
		cyl_t visit_cylinder;
		cyl_t step_distance;
		sum_t seek_total;
		logic overflow;
		logic last_visit;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	function automatic cyl_t seek_gap(input cyl_t a, input cyl_t b);
		seek_gap = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: src/sstf_front.sv
module sstf_front import sstf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  cyl_t  cylinder,
	input  logic  has_request,
	input  logic  last_request,
	input  cyl_t  start_head,
	input  logic  item_pop,
	output logic  item_vld,
	output item_t item
);

	item_t      buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	item_kind_t kind;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		case ({has_request, last_request})
			2'b00:   kind = K_NOP;
			2'b10:   kind = K_LOAD;
			2'b01:   kind = K_RUN;
			2'b11:   kind = K_LOAD_RUN;
			default: kind = K_NOP;
		endcase
	end

	assign full     = (cnt_q == 2'd2);
	assign item_vld = (cnt_q != 2'd0);
	assign item     = buf_q[rp_q];
	assign do_push  = push && !full && (kind != K_NOP);
	assign do_pop   = item_pop && item_vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= '{kind: kind, cylinder: cylinder, start_head: start_head};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// File: src/sstf_back.sv
module sstf_back import sstf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_vld,
	input  item_t item,
	output logic  item_pop,
	input  logic  res_full,
	output logic  res_push,
	output res_t  res
);

	state_t               state_q;
	state_t               state_nx;
	cyl_t                 mem [MAX_PENDING];
	cyl_t                 rdata_s1;
	idx_t                 idx_s1;
	logic                 vld_s1;
	logic [MAX_PENDING-1:0] served_q;
	cnt_t                 cnt_q;
	cnt_t                 issue_q;
	cnt_t                 done_q;
	logic                 ovf_q;
	cyl_t                 head_q;
	sum_t                 sum_q;
	logic                 found_q;
	cyl_t                 best_d_q;
	idx_t                 best_i_q;
	cyl_t                 best_cyl_q;

	logic                 load;
	logic                 run;
	logic                 fits;
	cnt_t                 cnt_nx;
	logic                 ovf_nx;
	logic                 issue;
	cyl_t                 cand;
	logic                 take;
	logic [SUM_W:0]       sum_ext;
	sum_t                 sum_sat;
	logic                 last_step;
	logic                 finish;
	logic                 start_scan;

	assign fits      = (cnt_q < CNT_W'(MAX_PENDING));
	assign issue     = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign cand      = seek_gap(rdata_s1, head_q);
	assign take      = vld_s1 && !served_q[idx_s1] && (!found_q || (cand < best_d_q));
	assign sum_ext   = {1'b0, sum_q} + (SUM_W + 1)'(best_d_q);
	assign sum_sat   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
	assign last_step = ((done_q + CNT_W'(1)) == cnt_q);

	always_comb begin
		state_nx   = state_q;
		item_pop   = 1'b0;
		load       = 1'b0;
		run        = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		finish     = 1'b0;
		start_scan = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_pop = item_vld;
				load     = item_vld && (item.kind inside {K_LOAD, K_LOAD_RUN});
				run      = item_vld && (item.kind inside {K_RUN, K_LOAD_RUN});
				if (run) begin
					state_nx = ST_HEAD;
				end
			end
			ST_HEAD: begin
				res_push = !res_full;
				res      = '{visit_cylinder: head_q, step_distance: '0,
					seek_total: '0, overflow: ovf_q, last_visit: (cnt_q == '0)};
				if (res_push) begin
					if (cnt_q == '0) begin
						finish   = 1'b1;
						state_nx = ST_IDLE;
					end else begin
						start_scan = 1'b1;
						state_nx   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!issue && !vld_s1) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				res_push = !res_full;
				res      = '{visit_cylinder: best_cyl_q, step_distance: best_d_q,
					seek_total: sum_sat, overflow: ovf_q, last_visit: last_step};
				if (res_push) begin
					if (last_step) begin
						finish   = 1'b1;
						state_nx = ST_IDLE;
					end else begin
						start_scan = 1'b1;
						state_nx   = ST_SCAN;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign cnt_nx = cnt_q + CNT_W'(load && fits);
	assign ovf_nx = ovf_q | (load && !fits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load && fits) begin
			mem[cnt_q[IDX_W-1:0]] <= item.cylinder;
		end
		rdata_s1 <= mem[issue_q[IDX_W-1:0]];
		idx_s1   <= issue_q[IDX_W-1:0];
		if (take) begin
			best_d_q   <= cand;
			best_i_q   <= idx_s1;
			best_cyl_q <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			served_q <= '0;
			cnt_q    <= '0;
			issue_q  <= '0;
			done_q   <= '0;
			ovf_q    <= 1'b0;
			head_q   <= '0;
			sum_q    <= '0;
			found_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (item_pop) begin
				cnt_q <= cnt_nx;
				ovf_q <= ovf_nx;
			end
			if (run) begin
				head_q <= item.start_head;
				sum_q  <= '0;
			end
			if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_EMIT && res_push) begin
				head_q <= best_cyl_q;
				if (last_step) begin
					served_q <= '0;
					sum_q    <= '0;
					done_q   <= '0;
				end else begin
					served_q[best_i_q] <= 1'b1;
					sum_q              <= sum_sat;
					done_q             <= done_q + CNT_W'(1);
				end
			end
			if (start_scan) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end
			if (finish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/sstf_rq.sv
module sstf_rq import sstf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_in,
	output logic res_full,
	input  logic pop,
	output logic empty,
	output res_t res_out
);

	res_t       buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = buf_q[rp_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// File: src/shortest_seek_first_scheduler.sv
// Shortest-seek-first ordering of a batch of cylinder requests.
// Input queue: drive the word on cylinder/has_request/last_request/start_head
// with push; it is taken on a clock edge where push is high and full is low.
// Words with has_request load one request each (up to 32; extras are
// dropped and flag overflow). The last word sets the start head and starts
// the batch: the start head comes out first, then every request, nearest
// first. Result queue: the oldest word sits on the result ports while empty
// is low; pop takes it. last_visit marks the final word of a batch.
// Engine: input words are taken only while idle. Each request is found
// by a scan of the pending store, one entry per cycle, with a single
// distance comparator.
// Two-word queues sit on both sides; when the receiver stalls the engine
// holds its result and the input queue fills, then full rises.
// Reset clears all queues, the batch count, the overflow flag, the head
// position and the distance total.
module shortest_seek_first_scheduler import sstf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [CYL_W-1:0]       cylinder,
	input  logic                   has_request,
	input  logic                   last_request,
	input  logic [CYL_W-1:0]       start_head,
	input  logic                   pop,
	output logic                   empty,
	output logic [CYL_W-1:0]       visit_cylinder,
	output logic [CYL_W-1:0]       step_distance,
	output logic [SUM_W-1:0]       seek_total,
	output logic                   overflow,
	output logic                   last_visit
);

	item_t item;
	logic  item_vld;
	logic  item_pop;
	res_t  res_in;
	res_t  res_out;
	logic  res_push;
	logic  res_full;

	sstf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cylinder     (cylinder),
		.has_request  (has_request),
		.last_request (last_request),
		.start_head   (start_head),
		.item_pop     (item_pop),
		.item_vld     (item_vld),
		.item         (item)
	);

	sstf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (item_vld),
		.item     (item),
		.item_pop (item_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	sstf_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign visit_cylinder = res_out.visit_cylinder;
	assign step_distance  = res_out.step_distance;
	assign seek_total     = res_out.seek_total;
	assign overflow       = res_out.overflow;
	assign last_visit     = res_out.last_visit;

endmodule
